FILE: hdl/chm_pkg.sv
// Package for the chained hash map: default sizes, operation and status codes,
// and the sequencer state type. No dependencies.
package chm_pkg;

   localparam int NODES_DEF           = 1024;
   localparam int MAX_BUCKETS_DEF     = 256;
   localparam int INITIAL_BUCKETS_DEF = 4;
   localparam int KEY_BITS_DEF        = 64;

   localparam logic [7:0] BUDGET_RESET = 8'd128;
   localparam logic [6:0] LOAD_RESET   = 7'd8;

   localparam logic CSR_BUDGET = 1'b0;
   localparam logic CSR_LOAD   = 1'b1;

   typedef enum logic [1:0] {
      KIND_INSERT = 2'd0,
      KIND_LOOKUP = 2'd1,
      KIND_REMOVE = 2'd2,
      KIND_UNUSED = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      STAT_OK       = 2'd0,
      STAT_NOTFOUND = 2'd1,
      STAT_FULL     = 2'd2,
      STAT_RSVD     = 2'd3
   } status_type;

   typedef enum logic [4:0] {
      ST_INIT,
      ST_IDLE,
      ST_INS_RD,
      ST_INS_WT,
      ST_PLACE_RD,
      ST_PLACE_WT,
      ST_LOAD,
      ST_MIG,
      ST_MIG_WT,
      ST_MIG_ND,
      ST_AFTER_MIG,
      ST_HEAD_RD,
      ST_HEAD_WT,
      ST_CHK,
      ST_NODE_WT,
      ST_RM_UNLINK,
      ST_RM_FREE,
      ST_RESP
   } state_type;

endpackage

FILE: hdl/chm_if.sv
// Request and response channel interfaces of the chained hash map.
// Depends on nothing.
interface chm_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [31:0] hash_code;
   logic [63:0] key_word;
   logic [31:0] value_word;
   modport source (output valid, kind, hash_code, key_word, value_word, input ready);
   modport sink (input valid, kind, hash_code, key_word, value_word, output ready);
endinterface

interface chm_rsp_if;
   logic        valid;
   logic        ready;
   logic        found;
   logic [31:0] value_out;
   logic [1:0]  status;
   logic [10:0] entry_count;
   modport source (output valid, found, value_out, status, entry_count, input ready);
   modport sink (input valid, found, value_out, status, entry_count, output ready);
endinterface

FILE: hdl/chained_hash_map_incremental_rehash_top.sv
// Top level of the chained hash map with incremental rehashing.
// Depends on chm_pkg, chm_if.sv and chm_ram.
//
//   Channel  Dir  Handshake          Payload
//   req      in   valid/ready        kind, hash_code, key_word, value_word
//   rsp      out  valid/ready        found, value_out, status, entry_count
//   csr      in   write enable only  csr_index, csr_wdata
//
// Migration moves a node through ST_MIG, ST_MIG_WT, ST_MIG_ND, ST_PLACE_RD and
// ST_PLACE_WT and scans an empty bucket in ST_MIG and ST_MIG_WT; a chain node
// is visited in ST_CHK and ST_NODE_WT, as the head and link RAMs are single-port.
// After reset a clearing pass in ST_INIT fills the head memory with null links
// and chains the free list; req.ready stays low.
// A finished response waits in an output register while the next transfer
// is taken.
module chained_hash_map_incremental_rehash_top
   import chm_pkg::*;
#(
   parameter int NODES           = NODES_DEF,
   parameter int MAX_BUCKETS     = MAX_BUCKETS_DEF,
   parameter int INITIAL_BUCKETS = INITIAL_BUCKETS_DEF,
   parameter int KEY_BITS        = KEY_BITS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   chm_req_if.sink    req,
   chm_rsp_if.source  rsp,
   input  logic       csr_we,
   input  logic       csr_index,
   input  logic [7:0] csr_wdata
);

   localparam int NW = $clog2(NODES);
   localparam int LW = $clog2(NODES + 1);
   localparam int BW = $clog2(MAX_BUCKETS);
   localparam int SW = $clog2(BW + 1);
   localparam int IW = (NW > BW + 1) ? NW : BW + 1;
   localparam int DW = KEY_BITS + 64;
   localparam int INIT_N = (INITIAL_BUCKETS <= MAX_BUCKETS) ? INITIAL_BUCKETS : MAX_BUCKETS;
   localparam logic [LW-1:0] NIL = LW'(NODES);
   localparam logic [BW-1:0] INIT_MASK = BW'(INIT_N - 1);
   localparam logic [SW-1:0] INIT_SH = SW'($clog2(INIT_N));

   state_type state_ff, state_in;

   logic [7:0]          budget_ff;
   logic [6:0]          max_load_ff;
   logic [IW-1:0]       init_ff, init_in;
   logic [LW-1:0]       free_ff, free_in;
   logic [BW-1:0]       new_mask_ff, new_mask_in, old_mask_ff, old_mask_in;
   logic [SW-1:0]       sh_ff, sh_in;
   logic [LW-1:0]       new_cnt_ff, new_cnt_in, old_cnt_ff, old_cnt_in;
   logic                mig_ff, mig_in, present_ff, present_in, sel_ff, sel_in;
   logic [BW-1:0]       scan_ff, scan_in;
   logic [7:0]          work_ff, work_in;
   logic [BW:0]         guard_ff, guard_in;
   logic [1:0]          kind_ff, kind_in;
   logic [31:0]         hash_ff, hash_in, val_ff, val_in;
   logic [KEY_BITS-1:0] key_ff, key_in;
   logic [LW-1:0]       node_ff, node_in, cur_ff, cur_in, prev_ff, prev_in;
   logic [LW-1:0]       nlink_ff, nlink_in;
   logic [BW-1:0]       bkt_ff, bkt_in;
   logic                ret_ff, ret_in, tbl_ff, tbl_in;
   logic                found_ff, found_in;
   logic [31:0]         vout_ff, vout_in;
   logic [1:0]          stat_ff, stat_in;

   logic                rv_ff, rv_in, rf_ff, rf_in;
   logic [31:0]         rval_ff, rval_in;
   logic [1:0]          rstat_ff, rstat_in;
   logic [10:0]         rcnt_ff, rcnt_in;

   logic                h_en, h_we, l_en, l_we, d_en, d_we;
   logic [BW:0]         h_addr;
   logic [NW-1:0]       l_addr, d_addr;
   logic [LW-1:0]       h_wdata, h_rdata, l_wdata, l_rdata;
   logic [DW-1:0]       d_wdata, d_rdata;

   logic                accept, do_double, key_hit, mig_go;
   logic [BW-1:0]       old_bkt;
   logic [31:0]         ld_lhs, cnt_sum;

   chm_ram #(.WIDTH(LW), .DEPTH(2 * MAX_BUCKETS)) u_heads (
      .clock(clock), .en(h_en), .we(h_we), .addr(h_addr), .wdata(h_wdata), .rdata(h_rdata)
   );
   chm_ram #(.WIDTH(LW), .DEPTH(NODES)) u_links (
      .clock(clock), .en(l_en), .we(l_we), .addr(l_addr), .wdata(l_wdata), .rdata(l_rdata)
   );
   chm_ram #(.WIDTH(DW), .DEPTH(NODES)) u_nodes (
      .clock(clock), .en(d_en), .we(d_we), .addr(d_addr), .wdata(d_wdata), .rdata(d_rdata)
   );

   assign req.ready = (state_ff == ST_IDLE);
   assign accept    = req.valid && req.ready;
   assign rsp.valid       = rv_ff;
   assign rsp.found       = rf_ff;
   assign rsp.value_out   = rval_ff;
   assign rsp.status      = rstat_ff;
   assign rsp.entry_count = rcnt_ff;

   assign old_bkt  = scan_ff & old_mask_ff;
   assign ld_lhs   = 32'(new_cnt_ff >> sh_ff);
   assign do_double = !mig_ff && (sh_ff < SW'(BW)) && (ld_lhs >= 32'(max_load_ff));
   assign key_hit  = (d_rdata[DW-1:64] == key_ff);
   assign mig_go   = (work_ff < budget_ff) && (old_cnt_ff != '0)
                     && (guard_ff < (BW + 1)'(MAX_BUCKETS));
   assign cnt_sum  = 32'(new_cnt_ff) + 32'(old_cnt_ff);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_INIT:      if (init_ff == '1) state_in = ST_IDLE;
         ST_IDLE: begin
            if (accept) begin
               unique case (kind_type'(req.kind))
                  KIND_INSERT: state_in = (free_ff == NIL) ? ST_MIG : ST_INS_RD;
                  KIND_LOOKUP, KIND_REMOVE: state_in = ST_MIG;
                  default:     state_in = ST_RESP;
               endcase
            end
         end
         ST_INS_RD:    state_in = ST_INS_WT;
         ST_INS_WT:    state_in = ST_PLACE_RD;
         ST_PLACE_RD:  state_in = ST_PLACE_WT;
         ST_PLACE_WT:  state_in = ret_ff ? ST_MIG : ST_LOAD;
         ST_LOAD:      state_in = ST_MIG;
         ST_MIG:       state_in = (mig_ff && mig_go) ? ST_MIG_WT : ST_AFTER_MIG;
         ST_MIG_WT:    state_in = (h_rdata == NIL) ? ST_MIG : ST_MIG_ND;
         ST_MIG_ND:    state_in = ST_PLACE_RD;
         ST_AFTER_MIG: begin
            if (kind_ff == KIND_INSERT) state_in = ST_RESP;
            else if (present_ff) state_in = ST_HEAD_RD;
            else state_in = ST_RESP;
         end
         ST_HEAD_RD:   state_in = ST_HEAD_WT;
         ST_HEAD_WT:   state_in = ST_CHK;
         ST_CHK: begin
            if (cur_ff != NIL) state_in = ST_NODE_WT;
            else if (!tbl_ff && mig_ff) state_in = ST_HEAD_RD;
            else state_in = ST_RESP;
         end
         ST_NODE_WT: begin
            if (!key_hit) state_in = ST_CHK;
            else if (kind_ff == KIND_REMOVE) state_in = ST_RM_UNLINK;
            else state_in = ST_RESP;
         end
         ST_RM_UNLINK: state_in = ST_RM_FREE;
         ST_RM_FREE:   state_in = ST_RESP;
         ST_RESP:      if (!rv_ff || rsp.ready) state_in = ST_IDLE;
         default:      state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      init_in = init_ff;  free_in = free_ff;  new_mask_in = new_mask_ff;
      old_mask_in = old_mask_ff;  sh_in = sh_ff;  new_cnt_in = new_cnt_ff;
      old_cnt_in = old_cnt_ff;  mig_in = mig_ff;  present_in = present_ff;
      sel_in = sel_ff;  scan_in = scan_ff;  work_in = work_ff;  guard_in = guard_ff;
      kind_in = kind_ff;  hash_in = hash_ff;  val_in = val_ff;  key_in = key_ff;
      node_in = node_ff;  cur_in = cur_ff;  prev_in = prev_ff;  nlink_in = nlink_ff;
      bkt_in = bkt_ff;  ret_in = ret_ff;  tbl_in = tbl_ff;  found_in = found_ff;
      vout_in = vout_ff;  stat_in = stat_ff;
      rv_in = rv_ff;  rf_in = rf_ff;  rval_in = rval_ff;  rstat_in = rstat_ff;
      rcnt_in = rcnt_ff;
      h_en = 1'b0;  h_we = 1'b0;  h_addr = '0;  h_wdata = NIL;
      l_en = 1'b0;  l_we = 1'b0;  l_addr = '0;  l_wdata = NIL;
      d_en = 1'b0;  d_we = 1'b0;  d_addr = '0;
      d_wdata = {key_ff, val_ff, hash_ff};

      if (rv_ff && rsp.ready) rv_in = 1'b0;

      unique case (state_ff)
         ST_INIT: begin
            h_en = 1'b1;  h_we = 1'b1;  h_addr = init_ff[BW:0];  h_wdata = NIL;
            l_en = ({1'b0, init_ff} < (IW + 1)'(NODES));
            l_we = 1'b1;
            l_addr = init_ff[NW-1:0];
            l_wdata = LW'(init_ff[NW-1:0]) + LW'(1);
            init_in = init_ff + IW'(1);
         end
         ST_IDLE: begin
            if (accept) begin
               kind_in = req.kind;  hash_in = req.hash_code;
               key_in = req.key_word[KEY_BITS-1:0];  val_in = req.value_word;
               found_in = 1'b0;  vout_in = '0;  stat_in = STAT_OK;
               work_in = '0;  guard_in = '0;
               if (req.kind == KIND_INSERT) begin
                  if (!present_ff) begin
                     present_in = 1'b1;  new_mask_in = INIT_MASK;  sh_in = INIT_SH;
                  end
                  if (free_ff == NIL) stat_in = STAT_FULL;
               end
            end
         end
         ST_INS_RD: begin
            l_en = 1'b1;  l_addr = free_ff[NW-1:0];
         end
         ST_INS_WT: begin
            free_in = l_rdata;  node_in = free_ff;
            d_en = 1'b1;  d_we = 1'b1;  d_addr = free_ff[NW-1:0];
            bkt_in = hash_ff[BW-1:0] & new_mask_ff;  ret_in = 1'b0;
         end
         ST_PLACE_RD: begin
            h_en = 1'b1;  h_addr = {sel_ff, bkt_ff};
         end
         ST_PLACE_WT: begin
            l_en = 1'b1;  l_we = 1'b1;  l_addr = node_ff[NW-1:0];  l_wdata = h_rdata;
            h_en = 1'b1;  h_we = 1'b1;  h_addr = {sel_ff, bkt_ff};  h_wdata = node_ff;
            new_cnt_in = new_cnt_ff + LW'(1);
         end
         ST_LOAD: begin
            if (do_double) begin
               sel_in = !sel_ff;  old_mask_in = new_mask_ff;  old_cnt_in = new_cnt_ff;
               new_mask_in = {new_mask_ff[BW-2:0], 1'b1};  sh_in = sh_ff + SW'(1);
               new_cnt_in = '0;  scan_in = '0;  mig_in = 1'b1;
            end
         end
         ST_MIG: begin
            if (mig_ff && mig_go) begin
               h_en = 1'b1;  h_addr = {!sel_ff, old_bkt};
            end else if (mig_ff && old_cnt_ff == '0) begin
               mig_in = 1'b0;
            end
         end
         ST_MIG_WT: begin
            if (h_rdata == NIL) begin
               scan_in = scan_ff + BW'(1);  guard_in = guard_ff + (BW + 1)'(1);
            end else begin
               node_in = h_rdata;
               l_en = 1'b1;  l_addr = h_rdata[NW-1:0];
               d_en = 1'b1;  d_addr = h_rdata[NW-1:0];
            end
         end
         ST_MIG_ND: begin
            h_en = 1'b1;  h_we = 1'b1;  h_addr = {!sel_ff, old_bkt};  h_wdata = l_rdata;
            old_cnt_in = old_cnt_ff - LW'(1);
            bkt_in = d_rdata[BW-1:0] & new_mask_ff;
            work_in = work_ff + 8'd1;  ret_in = 1'b1;
         end
         ST_AFTER_MIG: begin
            tbl_in = 1'b0;
            if (kind_ff != KIND_INSERT && !present_ff) stat_in = STAT_NOTFOUND;
         end
         ST_HEAD_RD: begin
            bkt_in = hash_ff[BW-1:0] & (tbl_ff ? old_mask_ff : new_mask_ff);
            h_en = 1'b1;
            h_addr = {tbl_ff ? !sel_ff : sel_ff,
                      hash_ff[BW-1:0] & (tbl_ff ? old_mask_ff : new_mask_ff)};
            prev_in = NIL;
         end
         ST_HEAD_WT: cur_in = h_rdata;
         ST_CHK: begin
            if (cur_ff != NIL) begin
               l_en = 1'b1;  l_addr = cur_ff[NW-1:0];
               d_en = 1'b1;  d_addr = cur_ff[NW-1:0];
            end else if (!tbl_ff && mig_ff) begin
               tbl_in = 1'b1;
            end else begin
               stat_in = STAT_NOTFOUND;
            end
         end
         ST_NODE_WT: begin
            if (key_hit) begin
               found_in = 1'b1;  vout_in = d_rdata[63:32];
               node_in = cur_ff;  nlink_in = l_rdata;
            end else begin
               prev_in = cur_ff;  cur_in = l_rdata;
            end
         end
         ST_RM_UNLINK: begin
            if (prev_ff != NIL) begin
               l_en = 1'b1;  l_we = 1'b1;  l_addr = prev_ff[NW-1:0];  l_wdata = nlink_ff;
            end else begin
               h_en = 1'b1;  h_we = 1'b1;
               h_addr = {tbl_ff ? !sel_ff : sel_ff, bkt_ff};  h_wdata = nlink_ff;
            end
         end
         ST_RM_FREE: begin
            l_en = 1'b1;  l_we = 1'b1;  l_addr = node_ff[NW-1:0];  l_wdata = free_ff;
            free_in = node_ff;
            if (!tbl_ff) begin
               new_cnt_in = new_cnt_ff - LW'(1);
            end else begin
               old_cnt_in = old_cnt_ff - LW'(1);
               if (old_cnt_ff == LW'(1)) mig_in = 1'b0;
            end
         end
         ST_RESP: begin
            if (!rv_ff || rsp.ready) begin
               rv_in = 1'b1;  rf_in = found_ff;  rval_in = vout_ff;
               rstat_in = stat_ff;  rcnt_in = cnt_sum[10:0];
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;  init_ff <= '0;  free_ff <= '0;
         new_mask_ff <= '0;  old_mask_ff <= '0;  sh_ff <= '0;
         new_cnt_ff <= '0;  old_cnt_ff <= '0;  mig_ff <= 1'b0;
         present_ff <= 1'b0;  sel_ff <= 1'b0;  scan_ff <= '0;
         rv_ff <= 1'b0;
         budget_ff <= BUDGET_RESET;  max_load_ff <= LOAD_RESET;
      end else begin
         state_ff <= state_in;  init_ff <= init_in;  free_ff <= free_in;
         new_mask_ff <= new_mask_in;  old_mask_ff <= old_mask_in;  sh_ff <= sh_in;
         new_cnt_ff <= new_cnt_in;  old_cnt_ff <= old_cnt_in;  mig_ff <= mig_in;
         present_ff <= present_in;  sel_ff <= sel_in;  scan_ff <= scan_in;
         rv_ff <= rv_in;
         if (csr_we && csr_index == CSR_BUDGET) budget_ff <= csr_wdata;
         if (csr_we && csr_index == CSR_LOAD) max_load_ff <= csr_wdata[6:0];
      end
   end

   always_ff @(posedge clock) begin
      work_ff <= work_in;  guard_ff <= guard_in;  kind_ff <= kind_in;
      hash_ff <= hash_in;  val_ff <= val_in;  key_ff <= key_in;
      node_ff <= node_in;  cur_ff <= cur_in;  prev_ff <= prev_in;
      nlink_ff <= nlink_in;  bkt_ff <= bkt_in;  ret_ff <= ret_in;  tbl_ff <= tbl_in;
      found_ff <= found_in;  vout_ff <= vout_in;  stat_ff <= stat_in;
      rf_ff <= rf_in;  rval_ff <= rval_in;  rstat_ff <= rstat_in;  rcnt_ff <= rcnt_in;
   end

endmodule

FILE: hdl/chm_ram.sv
// Generic single-port RAM with a registered read, used for all map storage.
// Depends on nothing.
module chm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     en,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (en && we) begin
         mem_ff[addr] <= wdata;
      end else if (en) begin
         rdata_ff <= mem_ff[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule
